@@ design/clpg_pkg.sv @@
// ----------------------------------------------------------------------------
// clpg_pkg
// Shared types and constants for the clipped line pixel generator.
// ----------------------------------------------------------------------------
package clpg_pkg;

    // Clip limit for the resolution registers
    localparam logic [11:0] MAX_RES = 12'd2048;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BPP    = 2'd2;

    // Line kinds
    localparam logic [1:0] KIND_HORIZONTAL = 2'd0;
    localparam logic [1:0] KIND_VERTICAL   = 2'd1;
    localparam logic [1:0] KIND_SLOPED     = 2'd2;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        busy;
        logic [15:0] quotient;
        logic [15:0] remainder;
    } div_status_t;

endpackage

@@ design/clpg_div.sv @@
// ----------------------------------------------------------------------------
// clpg_div
// Restoring unsigned divider, 16 by 16 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clpg_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [15:0]          dividend,
    input  logic [15:0]          divisor,
    output clpg_pkg::div_status_t status
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [clpg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [clpg_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [15:0]                    rem_reg;
    logic [15:0]                    rem_next;
    logic [15:0]                    quo_reg;
    logic [15:0]                    quo_next;
    logic [15:0]                    dvs_reg;
    logic [15:0]                    dvs_next;
    logic [16:0]                    shifted;
    logic [17:0]                    diff;

    assign shifted = {rem_reg, quo_reg[15]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not borrow
            if (!diff[17])
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == clpg_pkg::DIV_CNT_W'(clpg_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy      = busy_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg;

endmodule

@@ design/clpg_addr.sv @@
// ----------------------------------------------------------------------------
// clpg_addr
// Two-step framebuffer address unit: row product, then column add and
// byte scaling.
// ----------------------------------------------------------------------------
module clpg_addr (
    input  logic        clk,
    input  logic        load,
    input  logic [10:0] pix_y,
    input  logic [10:0] pix_x,
    input  logic [11:0] width,
    input  logic [2:0]  bpp,
    output logic [23:0] addr
);

    logic [22:0] prod_reg;
    logic [22:0] prod_next;
    logic [22:0] lin;
    logic [25:0] scaled;

    assign prod_next = {12'd0, pix_y} * {11'd0, width};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // on-screen pixels keep y*width + x below 2^23
    assign lin    = prod_reg + {12'd0, pix_x};
    assign scaled = {3'd0, lin} * {23'd0, bpp};
    assign addr   = scaled[23:0];

endmodule

@@ design/clipped_line_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// clipped_line_pixel_generator_core
// Line rasterizer: start beats arm a line, step beats on an active line emit one byte write.
// ----------------------------------------------------------------------------
// Step beat: pixel registered, row product in ST_MUL, result in ST_WR once
// the output register is free; input stalls until ST_IDLE. Start beat of a
// sloped line: input stalls in ST_DIV while the divider forms the slope, one
// quotient bit per cycle over 16 iterations. Other beats leave the block in ST_IDLE.
// Reset clears control state; registers return to 1024 x 768, 1 byte/pixel.
module clipped_line_pixel_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    input  logic [7:0]  pixel_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_enable,
    output logic [23:0] byte_address,
    output logic [7:0]  write_color,
    output logic        line_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_WR   = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [2:0]  bpp_reg;
    logic [11:0] cfg_sat;

    logic        active_reg;
    logic        active_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [15:0] cur_x_reg;
    logic [15:0] cur_x_next;
    logic [16:0] cur_y_reg;
    logic [16:0] cur_y_next;
    logic [15:0] stop_reg;
    logic [15:0] stop_next;
    logic [16:0] quot_reg;
    logic [16:0] quot_next;
    logic [15:0] srem_reg;
    logic [15:0] srem_next;
    logic [15:0] frac_reg;
    logic [15:0] frac_next;
    logic [15:0] dx_reg;
    logic [15:0] dx_next;
    logic        neg_reg;
    logic        neg_next;
    logic [7:0]  color_reg;
    logic [7:0]  color_next;

    logic [10:0] pix_x_reg;
    logic [10:0] pix_x_next;
    logic [10:0] pix_y_reg;
    logic [10:0] pix_y_next;
    logic        on_reg;
    logic        on_next;
    logic        last_reg;
    logic        last_next;

    logic        ov_reg;
    logic        ov_next;
    logic        we_reg;
    logic [23:0] addr_reg;
    logic [7:0]  wcol_reg;
    logic        done_reg;

    logic        in_take;
    logic        out_take;
    logic        out_free;
    logic        div_start;
    logic [15:0] lx;
    logic [15:0] rx;
    logic [15:0] ly;
    logic [15:0] ry;
    logic [15:0] dy_mag;
    logic        on_scr;
    logic        step_last;
    logic [16:0] rsum;
    logic        carry;
    logic [23:0] addr_calc;

    clpg_pkg::div_status_t div_st;

    assign in_take  = in_valid && !in_stall;
    assign out_take = ov_reg && !out_stall;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // configuration
    assign cfg_sat = (cfg_data > clpg_pkg::MAX_RES) ? clpg_pkg::MAX_RES : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd1024;
            height_reg <= 12'd768;
            bpp_reg    <= 3'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                clpg_pkg::CFG_WIDTH:  width_reg  <= cfg_sat;
                clpg_pkg::CFG_HEIGHT: height_reg <= cfg_sat;
                clpg_pkg::CFG_BPP:    bpp_reg    <= cfg_data[2:0];
                default:              ;
            endcase
        end
    end

    // left and right endpoints of a sloped line
    assign lx = (start_x > end_x) ? end_x : start_x;
    assign rx = (start_x > end_x) ? start_x : end_x;
    assign ly = (start_x > end_x) ? end_y : start_y;
    assign ry = (start_x > end_x) ? start_y : end_y;
    assign dy_mag = (ry < ly) ? (ly - ry) : (ry - ly);

    assign div_start = in_take && (operation == clpg_pkg::OP_START)
                       && (start_y != end_y) && (start_x != end_x);

    clpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dy_mag),
        .divisor  (rx - lx),
        .status   (div_st)
    );

    // current pixel
    assign on_scr = ({4'd0, width_reg} > cur_x_reg) && ({5'd0, height_reg} > cur_y_reg);
    assign rsum   = {1'b0, srem_reg} + {1'b0, frac_reg};
    assign carry  = (rsum >= {1'b0, dx_reg});

    always_comb
    begin
        case (kind_reg)
            clpg_pkg::KIND_HORIZONTAL: step_last = ({1'b0, cur_x_reg} + 17'd1) == {1'b0, stop_reg};
            clpg_pkg::KIND_VERTICAL:   step_last = (cur_y_reg + 17'd1) == {1'b0, stop_reg};
            default:                   step_last = (cur_x_reg == stop_reg);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        kind_next   = kind_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        stop_next   = stop_reg;
        quot_next   = quot_reg;
        srem_next   = srem_reg;
        frac_next   = frac_reg;
        dx_next     = dx_reg;
        neg_next    = neg_reg;
        color_next  = color_reg;
        pix_x_next  = pix_x_reg;
        pix_y_next  = pix_y_reg;
        on_next     = on_reg;
        last_next   = last_reg;
        ov_next     = out_take ? 1'b0 : ov_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (operation == clpg_pkg::OP_START))
                begin
                    color_next  = pixel_color;
                    active_next = 1'b1;
                    quot_next   = '0;
                    srem_next   = '0;
                    frac_next   = '0;
                    dx_next     = '0;
                    if (start_y == end_y)
                    begin
                        kind_next  = clpg_pkg::KIND_HORIZONTAL;
                        cur_y_next = {1'b0, start_y};
                        cur_x_next = (start_x < end_x) ? start_x : end_x;
                        stop_next  = (start_x < end_x) ? end_x : start_x;
                        // empty run when both endpoints coincide
                        if (start_x == end_x)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    else if (start_x == end_x)
                    begin
                        kind_next  = clpg_pkg::KIND_VERTICAL;
                        cur_x_next = start_x;
                        cur_y_next = {1'b0, (start_y < end_y) ? start_y : end_y};
                        stop_next  = (start_y < end_y) ? end_y : start_y;
                    end
                    else
                    begin
                        kind_next  = clpg_pkg::KIND_SLOPED;
                        cur_x_next = lx;
                        cur_y_next = {1'b0, ly};
                        stop_next  = rx;
                        dx_next    = rx - lx;
                        neg_next   = (ry < ly);
                        state_next = ST_DIV;
                    end
                end
                else if (in_take && active_reg)
                begin
                    pix_x_next = cur_x_reg[10:0];
                    pix_y_next = cur_y_reg[10:0];
                    on_next    = on_scr;
                    last_next  = step_last;
                    if (step_last)
                    begin
                        active_next = 1'b0;
                    end
                    case (kind_reg)
                        clpg_pkg::KIND_HORIZONTAL:
                        begin
                            cur_x_next = cur_x_reg + 16'd1;
                        end
                        clpg_pkg::KIND_VERTICAL:
                        begin
                            cur_y_next = cur_y_reg + 17'd1;
                        end
                        default:
                        begin
                            cur_x_next = cur_x_reg + 16'd1;
                            cur_y_next = cur_y_reg + quot_reg + {16'd0, carry};
                            srem_next  = carry ? 16'(rsum - {1'b0, dx_reg}) : rsum[15:0];
                        end
                    endcase
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (!div_st.busy)
                begin
                    // floor division: fold the sign back in
                    if (neg_reg && (div_st.remainder != 16'd0))
                    begin
                        quot_next = ~{1'b0, div_st.quotient};
                        frac_next = dx_reg - div_st.remainder;
                    end
                    else if (neg_reg)
                    begin
                        quot_next = 17'd0 - {1'b0, div_st.quotient};
                        frac_next = div_st.remainder;
                    end
                    else
                    begin
                        quot_next = {1'b0, div_st.quotient};
                        frac_next = div_st.remainder;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    clpg_addr u_addr (
        .clk   (clk),
        .load  (state_reg == ST_MUL),
        .pix_y (pix_y_reg),
        .pix_x (pix_x_reg),
        .width (width_reg),
        .bpp   (bpp_reg),
        .addr  (addr_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            kind_reg   <= clpg_pkg::KIND_HORIZONTAL;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            kind_reg   <= kind_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        stop_reg  <= stop_next;
        quot_reg  <= quot_next;
        srem_reg  <= srem_next;
        frac_reg  <= frac_next;
        dx_reg    <= dx_next;
        neg_reg   <= neg_next;
        color_reg <= color_next;
        pix_x_reg <= pix_x_next;
        pix_y_reg <= pix_y_next;
        on_reg    <= on_next;
        last_reg  <= last_next;
        if ((state_reg == ST_WR) && out_free)
        begin
            we_reg   <= on_reg;
            addr_reg <= on_reg ? addr_calc : 24'd0;
            wcol_reg <= color_reg;
            done_reg <= last_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign write_enable = we_reg;
    assign byte_address = addr_reg;
    assign write_color  = wcol_reg;
    assign line_done    = done_reg;

endmodule

@@ design/clpg_checker.sv @@
// ----------------------------------------------------------------------------
// clpg_checker
// Port-level checks for the clipped line pixel generator.
// ----------------------------------------------------------------------------
module clpg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        write_enable,
    input logic [23:0] byte_address,
    input logic        line_done
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(byte_address) && $stable(line_done))
        else $error("stalled result beat changed");

    // an input beat never yields a result in the very next cycle
    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after an input beat");

    // off-screen pixels carry a zero address
    a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> byte_address == 24'd0)
        else $error("clipped pixel with nonzero address");

endmodule

bind clipped_line_pixel_generator_core clpg_checker u_clpg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .byte_address (byte_address),
    .line_done    (line_done)
);

@@ verif/clipped_line_pixel_generator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_pixel_generator_core_tb
// Drives line starts and pixel steps through the valid/stall handshake under
// several screen setups. A scoreboard traces each armed line on its own and
// checks every emitted byte write field by field, in order.
// ----------------------------------------------------------------------------
module clipped_line_pixel_generator_core_tb;

    localparam logic [1:0] CFG_SPARE     = 2'd3;    // unmapped register index
    localparam int unsigned SETTLE_CYCLES = 24;     // covers the slope division
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned PRINT_CAP     = 50;

    typedef struct packed {
        logic        we;
        logic [23:0] addr;
        logic [7:0]  color;
        logic        done;
    } pixel_t;

    class line_scoreboard;
        int unsigned mismatches;
        int unsigned width;
        int unsigned height;
        int unsigned bpp;
        bit          active;
        logic [1:0]  kind;
        int unsigned cur_x;
        int unsigned cur_y;
        int unsigned stop;
        int          slope_q;
        int unsigned slope_frac;
        int unsigned slope_rem;
        int unsigned divisor;
        logic [7:0]  color;
        pixel_t      expected_pixels[$];

        function new();
            width  = 1024;
            height = 768;
            bpp    = 1;
            kind   = clpg_pkg::KIND_HORIZONTAL;
            color  = 8'd0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                clpg_pkg::CFG_WIDTH:
                    width  = 32'((data > clpg_pkg::MAX_RES) ? clpg_pkg::MAX_RES : data);
                clpg_pkg::CFG_HEIGHT:
                    height = 32'((data > clpg_pkg::MAX_RES) ? clpg_pkg::MAX_RES : data);
                clpg_pkg::CFG_BPP:
                    bpp    = 32'(data[2:0]);
                default:    ;
            endcase
        endfunction

        // Accepted input beat: arm a line, or trace the next pixel of it
        function void note_beat(logic op, logic [15:0] sx, logic [15:0] sy,
                                logic [15:0] ex, logic [15:0] ey, logic [7:0] col);
            int unsigned lx, ly, rx, ry, dx, x, y;
            int          dy, r;
            bit          on, last;
            longint unsigned lin;
            longint      ny;
            pixel_t      px;
            if (op == clpg_pkg::OP_START)
            begin
                color      = col;
                active     = 1'b1;
                slope_q    = 0;
                slope_rem  = 0;
                slope_frac = 0;
                divisor    = 0;
                if (sy == ey)
                begin
                    kind  = clpg_pkg::KIND_HORIZONTAL;
                    cur_y = 32'(sy);
                    cur_x = 32'((sx < ex) ? sx : ex);
                    stop  = 32'((sx < ex) ? ex : sx);
                    if (cur_x == stop)
                        active = 1'b0;
                end
                else if (sx == ex)
                begin
                    kind  = clpg_pkg::KIND_VERTICAL;
                    cur_x = 32'(sx);
                    cur_y = 32'((sy < ey) ? sy : ey);
                    stop  = 32'((sy < ey) ? ey : sy);
                end
                else
                begin
                    if (sx > ex)
                    begin
                        lx = 32'(ex); ly = 32'(ey); rx = 32'(sx); ry = 32'(sy);
                    end
                    else
                    begin
                        lx = 32'(sx); ly = 32'(sy); rx = 32'(ex); ry = 32'(ey);
                    end
                    dx = rx - lx;
                    dy = int'(ry) - int'(ly);
                    slope_q = dy / int'(dx);
                    r = dy - slope_q * int'(dx);
                    // floor, not truncation
                    if (r < 0)
                    begin
                        slope_q = slope_q - 1;
                        r = r + int'(dx);
                    end
                    kind       = clpg_pkg::KIND_SLOPED;
                    cur_x      = lx;
                    cur_y      = ly;
                    stop       = rx;
                    slope_frac = r;
                    divisor    = dx;
                end
                return;
            end
            if (!active)
                return;

            x   = cur_x;
            y   = cur_y;
            on  = (x < width) && (y < height);
            lin = (64'(y) * width + x) * bpp;
            if (kind == clpg_pkg::KIND_HORIZONTAL)
            begin
                last  = (x + 1 == stop);
                cur_x = (x + 1) & 32'hFFFF;
            end
            else if (kind == clpg_pkg::KIND_VERTICAL)
            begin
                last  = (y + 1 == stop);
                cur_y = (y + 1) & 32'h1FFFF;
            end
            else
            begin
                ny   = longint'(y) + slope_q;
                last = (x == stop);
                slope_rem = slope_rem + slope_frac;
                if (slope_rem >= divisor)
                begin
                    slope_rem = slope_rem - divisor;
                    ny = ny + 1;
                end
                cur_x = (x + 1) & 32'hFFFF;
                cur_y = 32'(ny & 64'h1FFFF);
            end
            if (last)
                active = 1'b0;

            px.we    = on;
            px.addr  = on ? lin[23:0] : 24'd0;
            px.color = color;
            px.done  = last;
            expected_pixels.push_back(px);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("unexpected write we=%0b addr=%06h color=%02h done=%0b",
                                 got.we, got.addr, got.color, got.done));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.we !== want.we)
                report($sformatf("write_enable %0b, want %0b", got.we, want.we));
            if (got.addr !== want.addr)
                report($sformatf("byte_address %06h, want %06h", got.addr, want.addr));
            if (got.color !== want.color)
                report($sformatf("write_color %02h, want %02h", got.color, want.color));
            if (got.done !== want.done)
                report($sformatf("line_done %0b, want %0b", got.done, want.done));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [7:0]  pixel_color;
    logic        out_valid;
    logic        out_stall;
    logic        write_enable;
    logic [23:0] byte_address;
    logic [7:0]  write_color;
    logic        line_done;

    line_scoreboard sb = new();
    int unsigned    idle_pct;
    int unsigned    cycles;

    clipped_line_pixel_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .pixel_color  (pixel_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .byte_address (byte_address),
        .write_color  (write_color),
        .line_done    (line_done)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("clipped_line_pixel_generator_core verification failed");
            $finish;
        end
    end

    // Receiver backpressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Sample at the falling edge: the beat is taken at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_pixel({write_enable, byte_address, write_color, line_done});
    end

    task automatic send_beat(input logic op, input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] ex, input logic [15:0] ey,
                             input logic [7:0] col);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        start_x     <= sx;
        start_y     <= sy;
        end_x       <= ex;
        end_y       <= ey;
        pixel_color <= col;
        do
            @(negedge clk);
        while (in_stall !== 1'b0);
        @(posedge clk);
        sb.note_beat(op, sx, sy, ex, ey, col);
    endtask

    // Step beats carry random endpoint fields that the block ignores
    task automatic step_line(input int unsigned n);
        repeat (n)
            send_beat(clpg_pkg::OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_screen(input logic [11:0] w, input logic [11:0] h,
                                  input logic [11:0] bytes);
        logic [1:0]  idx [4];
        logic [11:0] val [4];
        idx = '{clpg_pkg::CFG_WIDTH, clpg_pkg::CFG_HEIGHT, clpg_pkg::CFG_BPP, CFG_SPARE};
        val = '{w, h, bytes, 12'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic int unsigned nudge(int unsigned v, int unsigned reach);
        int unsigned d;
        d = $urandom_range(1, reach);
        if ($urandom_range(0, 1) == 1 || v < d)
            return v + d;
        return v - d;
    endfunction

    function automatic int unsigned span_of(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // One line: mostly complete, sometimes abandoned or overstepped
    task automatic random_line(inout int unsigned counted);
        int unsigned sx, sy, ex, ey, run, steps, roll;
        bit          wide;
        wide = ($urandom_range(0, 99) < 15);
        sx = $urandom_range(0, wide ? 65535 : sb.width + 8);
        sy = $urandom_range(0, wide ? 65535 : sb.height + 8);
        ex = wide ? $urandom_range(0, 65535) : nudge(sx, 24);
        ey = wide ? $urandom_range(0, 65535) : nudge(sy, 60);
        roll = $urandom_range(0, 99);
        if (roll < 35)
            ey = sy;
        else if (roll < 55)
            ex = sx;
        else if (roll < 60)
        begin
            ex = sx;
            ey = sy;
        end

        if (sy == ey)
            run = span_of(sx, ex);
        else if (sx == ex)
            run = span_of(sy, ey);
        else
            run = span_of(sx, ex) + 1;

        roll = $urandom_range(0, 99);
        if (run > 40)
            steps = $urandom_range(1, 40);
        else if (roll < 12)
            steps = (run == 0) ? 0 : $urandom_range(0, run - 1);
        else if (roll < 22)
            steps = run + $urandom_range(1, 3);
        else
            steps = run;

        if ($urandom_range(0, 99) < 4)
            step_line(1);
        send_beat(clpg_pkg::OP_START, 16'(sx), 16'(sy), 16'(ex), 16'(ey), 8'($urandom));
        step_line(steps);
        counted += 1 + ((steps < run) ? steps : run);
    endtask

    task automatic run_phase(input bit reprogram, input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] bytes, input int unsigned idle,
                             input int unsigned quota);
        int unsigned counted;
        counted = 0;
        if (reprogram)
        begin
            wait_drained();
            program_screen(w, h, bytes);
        end
        idle_pct = idle;
        while (counted < quota)
            random_line(counted);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = clpg_pkg::CFG_WIDTH;
        cfg_data    = 12'd0;
        in_valid    = 1'b0;
        operation   = clpg_pkg::OP_START;
        start_x     = 16'd0;
        start_y     = 16'd0;
        end_x       = 16'd0;
        end_y       = 16'd0;
        pixel_color = 8'd0;
        idle_pct    = 20;
        cycles      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        step_line(1);
        send_beat(clpg_pkg::OP_START, 16'd7, 16'd3, 16'd5, 16'd3, 8'hFF);
        step_line(2);
        send_beat(clpg_pkg::OP_START, 16'd2, 16'd0, 16'd2, 16'd3, 8'h00);
        step_line(3);
        send_beat(clpg_pkg::OP_START, 16'd0, 16'd0, 16'd3, 16'd2, 8'hA5);
        step_line(4);
        // steep line leaves gaps in y
        send_beat(clpg_pkg::OP_START, 16'd10, 16'd20, 16'd8, 16'd2, 8'h5A);
        step_line(3);
        // run across the right edge of the bottom row
        send_beat(clpg_pkg::OP_START, 16'd1022, 16'd767, 16'd1026, 16'd767, 8'h3C);
        step_line(4);
        send_beat(clpg_pkg::OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFD, 16'hFFFF, 8'hC3);
        step_line(2);
        // equal endpoints arm nothing
        send_beat(clpg_pkg::OP_START, 16'd7, 16'd7, 16'd7, 16'd7, 8'h81);
        step_line(1);

        run_phase(1'b0, 12'd0,    12'd0,    12'd0,    20, 140);
        run_phase(1'b1, 12'hFFF,  12'hFFF,  12'h004,  30, 140);
        run_phase(1'b1, 12'd1,    12'd1,    12'hFFF,  0,  140);
        run_phase(1'b1, 12'd0,    12'd0,    12'd0,    15, 120);
        run_phase(1'b1, 12'd640,  12'd480,  12'd3,    25, 150);
        run_phase(1'b1, 12'h801,  12'h7FF,  12'hFF2,  10, 150);
        run_phase(1'b1, 12'd320,  12'd200,  12'd5,    20, 150);
        // quiet tail: no idling on either side
        run_phase(1'b1, 12'd1024, 12'd768,  12'd1,    0,  150);

        wait_drained();
        if (sb.mismatches == 0)
            $display("clipped_line_pixel_generator_core verification clean");
        else
            $display("clipped_line_pixel_generator_core verification failed");
        $finish;
    end

endmodule
